### hdl/scet_pkg.sv
// ----------------------------------------------------------------------------
// scet_pkg
// Shared types, constants and register map for the sample change event
// trigger.
// ----------------------------------------------------------------------------
package scet_pkg;

  // Datapath sizes
  localparam int SAMPLE_BITS = 32;
  localparam int TIMER_BITS  = 16;
  localparam int CMP_BITS    = 34;   // holds sample, band and level sums exactly
  localparam int TCMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  // APB register map
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_BAND   = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_EDGE   = 3'd4;

  // Report modes
  typedef enum logic [1:0] {
    MODE_AUTO      = 2'd0,
    MODE_NOTEQUAL  = 2'd1,
    MODE_DEADBAND  = 2'd2,
    MODE_THRESHOLD = 2'd3
  } mode_e;

  // Threshold edge codes; the spare code reports nothing
  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  // Reset values
  localparam logic [15:0] PERIOD_RST = 16'd10;
  localparam logic [15:0] BAND_RST   = 16'd10;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // Configuration seen by the evaluation logic
  typedef struct packed {
    mode_e              mode;
    logic [15:0]        period;
    logic [15:0]        band;
    logic signed [31:0] thresh;
    logic [1:0]         edge_sel;
  } cfg_t;

  // Outcome of one tick
  typedef struct packed {
    logic                          report;
    logic [TIMER_BITS-1:0]         tick_next;
    logic signed [SAMPLE_BITS-1:0] rem_next;
  } eval_t;

endpackage

### hdl/scet_in_if.sv
// ----------------------------------------------------------------------------
// scet_in_if
// Sample channel: one beat per millisecond tick.
// ----------------------------------------------------------------------------
interface scet_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

### hdl/scet_out_if.sv
// ----------------------------------------------------------------------------
// scet_out_if
// Report channel: one beat per accepted tick.
// ----------------------------------------------------------------------------
interface scet_out_if;
  logic               valid;
  logic               ready;
  logic               report_event;
  logic signed [31:0] reported_value;

  modport source (output valid, output report_event, output reported_value, input ready);
  modport sink   (input valid, input report_event, input reported_value, output ready);
endinterface

### hdl/scet_cfg.sv
// ----------------------------------------------------------------------------
// scet_cfg
// APB configuration registers; flags a period write so the tick count restarts.
// ----------------------------------------------------------------------------
module scet_cfg
  import scet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              period_wr_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_NOTEQUAL;
      cfg_q.period   <= PERIOD_RST;
      cfg_q.band     <= BAND_RST;
      cfg_q.thresh   <= '0;
      cfg_q.edge_sel <= EDGE_RISE;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:   cfg_q.mode     <= mode_e'(pwdata[1:0]);
        REG_PERIOD: cfg_q.period   <= pwdata[15:0];
        REG_BAND:   cfg_q.band     <= pwdata[15:0];
        REG_THRESH: cfg_q.thresh   <= signed'(pwdata[31:0]);
        REG_EDGE:   cfg_q.edge_sel <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  assign period_wr_o = wr_en && (idx == REG_PERIOD);
  assign cfg_o       = cfg_q;

  // Read back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_MODE:   prdata[1:0]  = cfg_q.mode;
      REG_PERIOD: prdata[15:0] = cfg_q.period;
      REG_BAND:   prdata[15:0] = cfg_q.band;
      REG_THRESH: prdata       = cfg_q.thresh;
      REG_EDGE:   prdata[1:0]  = cfg_q.edge_sel;
      default:    prdata       = '0;
    endcase
  end

endmodule

### hdl/scet_eval.sv
// ----------------------------------------------------------------------------
// scet_eval
// Per-tick decision: advances the millisecond count and applies the report
// condition of the selected mode.
// ----------------------------------------------------------------------------
module scet_eval
  import scet_pkg::*;
(
  input  cfg_t                          cfg_i,
  input  logic [TIMER_BITS-1:0]         tick_i,
  input  logic signed [SAMPLE_BITS-1:0] rem_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output eval_t                         res_o
);

  logic [TIMER_BITS-1:0]      tick_inc;
  logic                       fire;
  logic signed [CMP_BITS-1:0] s_x, last_x, th_x, db_x;
  logic                       rise, fall, hit;

  // Saturating count, fires once the period has elapsed
  assign tick_inc = (tick_i != TIMER_MAX) ? tick_i + 1'b1 : tick_i;
  assign fire     = (TCMP_BITS'(tick_inc) >= TCMP_BITS'(cfg_i.period))
                 || (tick_inc == TIMER_MAX);

  // Widen everything so the compares cannot overflow
  assign s_x    = {{(CMP_BITS-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign last_x = {{(CMP_BITS-SAMPLE_BITS){rem_i[SAMPLE_BITS-1]}}, rem_i};
  assign th_x   = {{(CMP_BITS-32){cfg_i.thresh[31]}}, cfg_i.thresh};
  assign db_x   = {{(CMP_BITS-16){1'b0}}, cfg_i.band};

  assign rise = (last_x <= th_x) && (s_x > th_x);
  assign fall = (last_x > th_x) && (s_x <= th_x);

  // Mode condition
  always_comb begin
    case (cfg_i.mode)
      MODE_AUTO:     hit = 1'b1;
      MODE_NOTEQUAL: hit = (s_x != last_x);
      MODE_DEADBAND: hit = ((last_x > s_x + db_x) || (last_x < s_x - db_x))
                           && (s_x >= db_x);
      MODE_THRESHOLD:
        hit = (((cfg_i.edge_sel == EDGE_RISE) || (cfg_i.edge_sel == EDGE_BOTH)) && rise)
           || (((cfg_i.edge_sel == EDGE_FALL) || (cfg_i.edge_sel == EDGE_BOTH)) && fall);
      default:       hit = 1'b0;
    endcase
  end

  // Threshold mode remembers every evaluated sample, the others only on report
  assign res_o.report    = fire && hit;
  assign res_o.tick_next = fire ? '0 : tick_inc;
  assign res_o.rem_next  = (fire && (hit || (cfg_i.mode == MODE_THRESHOLD)))
                         ? sample_i : rem_i;

endmodule

### hdl/sample_change_event_trigger_top.sv
// ----------------------------------------------------------------------------
// sample_change_event_trigger_top
// Change-of-value report trigger for one channel, one tick per beat.
//
//   channel  dir  beat contents
//   smp_i    in   sample_value (32b signed), one millisecond tick
//   rpt_o    out  report_event (1b), reported_value (32b signed)
//   APB      in   report_mode, period_ms, band_size, threshold_level, edge_select
//
// One tick a cycle while rpt_o is not stalled; each result is registered and
// appears in the cycle after its tick is taken. The tick counter and
// remembered value update in the accepting cycle, so ticks follow back to back
// without a bubble. A stalled result register still takes a new tick when
// rpt_o is taken in the same cycle. Reset restores the register defaults and clears the count.
// ----------------------------------------------------------------------------
module sample_change_event_trigger_top
  import scet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  scet_in_if.sink           smp_i,
  scet_out_if.source        rpt_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t                          cfg;
  logic                          period_wr;
  eval_t                         ev;
  logic [TIMER_BITS-1:0]         tick_q;
  logic signed [SAMPLE_BITS-1:0] rem_q;
  logic                          vld_q, rep_q;
  logic signed [31:0]            val_q;
  logic                          acc;

  scet_cfg u_cfg (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o       (cfg),
    .period_wr_o (period_wr)
  );

  scet_eval u_eval (
    .cfg_i    (cfg),
    .tick_i   (tick_q),
    .rem_i    (rem_q),
    .sample_i (smp_i.sample_value[SAMPLE_BITS-1:0]),
    .res_o    (ev)
  );

  // Take a tick whenever the result register is free or being drained
  assign smp_i.ready = !vld_q || rpt_o.ready;
  assign acc         = smp_i.valid && smp_i.ready;

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      rem_q  <= SAMPLE_BITS'(1);
    end else if (period_wr) begin
      tick_q <= '0;
    end else if (acc) begin
      tick_q <= ev.tick_next;
      rem_q  <= ev.rem_next;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (acc) begin
      vld_q <= 1'b1;
    end else if (rpt_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rep_q <= ev.report;
      val_q <= ev.report
             ? 32'(signed'(smp_i.sample_value[SAMPLE_BITS-1:0])) : '0;
    end
  end

  assign rpt_o.valid          = vld_q;
  assign rpt_o.report_event   = rep_q;
  assign rpt_o.reported_value = val_q;

  // Checks
  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_o.valid && !rpt_o.report_event |-> rpt_o.reported_value == '0)
    else $error("non-report beat carries a value");

  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rpt_o.valid)
    else $error("accepted tick produced no result beat");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q != TIMER_MAX)
    else $error("tick count held at saturation");

endmodule
